/* rtl/lr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

  localparam int COORD_W = 6;
  localparam int FRAME_W = 7;
  localparam int ERR_W   = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t                    x0;
    coord_t                    y0;
    logic                      x_neg;
    logic                      y_neg;
    logic                      x_major;
    coord_t                    big;
    coord_t                    small_d;
    logic signed [ERR_W-1:0]   err;
  } lr_cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0] width;
    logic [FRAME_W-1:0] height;
  } lr_frame_t;

endpackage

`default_nettype wire

/* rtl/lr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module lr_front #(
  parameter int GRID_SIZE = 64
) (
  input  wire  logic          in_valid,
  output       logic          in_ready,
  input  wire  lr_pkg::coord_t in_start_x,
  input  wire  lr_pkg::coord_t in_start_y,
  input  wire  lr_pkg::coord_t in_end_x,
  input  wire  lr_pkg::coord_t in_end_y,
  output       logic          push,
  output       lr_pkg::lr_cmd_t cmd,
  input  wire  logic          queue_full
);
  import lr_pkg::*;

  localparam coord_t MAX_COORD = COORD_W'(GRID_SIZE - 1);

  coord_t x0, y0, x1, y1, ax, ay, big, small_d;
  logic   x_major;

  always_comb begin
    x0 = (in_start_x > MAX_COORD) ? MAX_COORD : in_start_x;
    y0 = (in_start_y > MAX_COORD) ? MAX_COORD : in_start_y;
    x1 = (in_end_x > MAX_COORD) ? MAX_COORD : in_end_x;
    y1 = (in_end_y > MAX_COORD) ? MAX_COORD : in_end_y;
    ax = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ay = (y1 >= y0) ? y1 - y0 : y0 - y1;
    x_major = (ax >= ay);
    big     = x_major ? ax : ay;
    small_d = x_major ? ay : ax;
    cmd.x0      = x0;
    cmd.y0      = y0;
    cmd.x_neg   = (x1 < x0);
    cmd.y_neg   = (y1 < y0);
    cmd.x_major = x_major;
    cmd.big     = big;
    cmd.small_d = small_d;
    cmd.err     = $signed({2'b00, small_d, 1'b0}) - $signed({3'b000, big});
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

endmodule

`default_nettype wire

/* rtl/lr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module lr_queue (
  input  wire  logic            clk,
  input  wire  logic            rst_n,
  input  wire  logic            push,
  input  wire  lr_pkg::lr_cmd_t push_cmd,
  output       logic            full,
  input  wire  logic            pop,
  output       logic            not_empty,
  output       lr_pkg::lr_cmd_t pop_cmd
);
  import lr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  lr_cmd_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;

  assign full      = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/lr_walk.sv */
`timescale 1ns / 1ps
`default_nettype none

module lr_walk (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  logic             cmd_valid,
  input  wire  lr_pkg::lr_cmd_t  cmd,
  output       logic             pop,
  input  wire  lr_pkg::lr_frame_t frame,
  output       logic             out_valid,
  input  wire  logic             out_ready,
  output       lr_pkg::coord_t   out_pixel_x,
  output       lr_pkg::coord_t   out_pixel_y,
  output       logic             out_visible,
  output       logic             out_last
);
  import lr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                  state_r;
  lr_cmd_t                 cmd_r;
  coord_t                  x_r, y_r, cnt_r;
  logic signed [ERR_W-1:0] err_r;
  logic                    out_valid_r;
  coord_t                  px_r, py_r;
  logic                    vis_r, last_r;

  logic                    emit;
  logic [ERR_W-1:0]        inc, dec;
  logic signed [ERR_W-1:0] err_nxt;
  coord_t                  x_nxt, y_nxt, x_step, y_step;
  logic                    minor_step;

  assign pop  = (state_r == ST_IDLE) && cmd_valid;
  assign emit = (state_r == ST_WALK) && (!out_valid_r || out_ready);

  always_comb begin
    inc = {2'b00, cmd_r.small_d, 1'b0};
    dec = {2'b00, cmd_r.big - cmd_r.small_d, 1'b0};
    minor_step = (err_r >= 0);
    err_nxt = minor_step ? err_r - $signed(dec) : err_r + $signed(inc);
    x_step = cmd_r.x_neg ? x_r - 1'b1 : x_r + 1'b1;
    y_step = cmd_r.y_neg ? y_r - 1'b1 : y_r + 1'b1;
    if (cmd_r.x_major) begin
      x_nxt = x_step;
      y_nxt = minor_step ? y_step : y_r;
    end else begin
      y_nxt = y_step;
      x_nxt = minor_step ? x_step : x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            x_r     <= cmd.x0;
            y_r     <= cmd.y0;
            err_r   <= cmd.err;
            cnt_r   <= cmd.big;
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (emit) begin
            px_r   <= x_r;
            py_r   <= y_r;
            vis_r  <= ({1'b0, x_r} < frame.width) && ({1'b0, y_r} < frame.height);
            last_r <= (cnt_r == '0);
            x_r    <= x_nxt;
            y_r    <= y_nxt;
            err_r  <= err_nxt;
            cnt_r  <= cnt_r - 1'b1;
            if (cnt_r == '0) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_visible = vis_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire

/* rtl/line_rasterizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line rasterizer for a GRID_SIZE by GRID_SIZE grid. Each accepted
// line command produces max(|dx|,|dy|)+1 pixel beats in walking order, the
// final one flagged by out_last; endpoint coordinates above GRID_SIZE-1 are
// saturated. The walk unit first loads a line from the queue, then emits one
// pixel per cycle unless out_ready stalls it, so that unit sets the rate. A
// two-entry command queue lets new commands be taken while a line is drawn.
// out_visible is clear when the pixel lies at or beyond the frame width or
// height set through the configuration port; write those only while idle.
module line_rasterizer #(
  parameter int GRID_SIZE = 64
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst_n,
  input  wire  logic                           cfg_we,
  input  wire  logic                           cfg_index,
  input  wire  logic [lr_pkg::FRAME_W-1:0]     cfg_wdata,
  input  wire  logic                           in_valid,
  output       logic                           in_ready,
  input  wire  lr_pkg::coord_t                 in_start_x,
  input  wire  lr_pkg::coord_t                 in_start_y,
  input  wire  lr_pkg::coord_t                 in_end_x,
  input  wire  lr_pkg::coord_t                 in_end_y,
  output       logic                           out_valid,
  input  wire  logic                           out_ready,
  output       lr_pkg::coord_t                 out_pixel_x,
  output       lr_pkg::coord_t                 out_pixel_y,
  output       logic                           out_visible,
  output       logic                           out_last
);
  import lr_pkg::*;

  lr_frame_t frame_r;
  lr_cmd_t   push_cmd, pop_cmd;
  logic      push, pop, full, not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r.width  <= FRAME_W'(64);
      frame_r.height <= FRAME_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_r.width  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_r.height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lr_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .push       (push),
    .cmd        (push_cmd),
    .queue_full (full)
  );

  lr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_cmd   (pop_cmd)
  );

  lr_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (not_empty),
    .cmd         (pop_cmd),
    .pop         (pop),
    .frame       (frame_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_visible (out_visible),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire
